// ----- design/apu_pkg.sv -----
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants for the fixed-point Adam parameter update block.
// ----------------------------------------------------------------------------
`default_nettype none

package apu_pkg;

    // Element store
    localparam int NUM_ELEMS = 4096;
    localparam int IDX_W     = 12;
    localparam int ADDR_W    = $clog2(NUM_ELEMS);

    // Datapath widths
    localparam int DATA_W   = 32;              // weight, gradient, m, coefficients
    localparam int V_W      = 64;              // second moment, Q8.56
    localparam int ROOT_W   = V_W / 2;         // integer square root
    localparam int REM_W    = ROOT_W + 2;      // square root partial remainder
    localparam int SQ_STEPS = ROOT_W;          // one root bit per stage
    localparam int DEN_W    = ROOT_W + 1;      // sqrt(v) + eps
    localparam int NUM_W    = 2 * DATA_W - 1;  // |m| * lr
    localparam int N_W      = NUM_W - 4;       // numerator over 16
    localparam int Q_W      = 34;              // quotient bits kept
    localparam int HI_W     = N_W - Q_W;       // numerator bits above the quotient
    localparam int DIV_STEPS = Q_W;            // one quotient bit per stage
    localparam int RES_W    = DATA_W + 4;      // weight plus/minus step

    localparam logic [Q_W-1:0] STEP_CLIP = Q_W'(64'h2_0000_0000);

    // Configuration register reset values
    localparam logic [DATA_W-1:0] LR_RESET  = 32'd4294967;
    localparam logic [DATA_W-1:0] B1_RESET  = 32'd3865470566;
    localparam logic [DATA_W-1:0] B2_RESET  = 32'd4290672329;
    localparam logic [DATA_W-1:0] EPS_RESET = 32'd3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STEP_SIZE     = 2'd0,
        CFG_BETA_FIRST    = 2'd1,
        CFG_BETA_SECOND   = 2'd2,
        CFG_EPSILON       = 2'd3
    } cfg_idx_t;

    // Per-word information that rides along the pipeline
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] w;
        logic              mneg;
        logic              mzero;
    } tag_t;

    typedef struct packed {
        logic valid;
        tag_t tag;
    } flow_t;

endpackage

`default_nettype wire

// ----- design/apu_ram.sv -----
// ----------------------------------------------------------------------------
// apu_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/apu_moment.sv -----
// ----------------------------------------------------------------------------
// apu_moment
// Input stage, moment stores and the four-stage moment update:
// read, multiply, sum and write back, then |m| * lr.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_moment
    import apu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic [DATA_W-1:0] step_size,
    input  wire logic [DATA_W-1:0] beta_first,
    input  wire logic [DATA_W-1:0] beta_second,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [IDX_W-1:0]  s_elem_index,
    input  wire logic [DATA_W-1:0] s_weight_in,
    input  wire logic [DATA_W-1:0] s_gradient,
    output flow_t                  out_flow,
    output logic      [V_W-1:0]    out_v,
    output logic      [NUM_W-1:0]  out_num
);

    // Clearing pass
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // Stage 1: input word, g*g
    logic                     p1_v_reg, p1_in_reg;
    logic [IDX_W-1:0]         p1_idx_reg;
    logic [DATA_W-1:0]        p1_w_reg;
    logic signed [DATA_W-1:0] p1_g_reg;
    logic [V_W-1:0]           p1_gg_reg;

    // Stage 2: partial products
    logic              p2_v_reg, p2_in_reg;
    logic [IDX_W-1:0]  p2_idx_reg;
    logic [DATA_W-1:0] p2_w_reg;
    logic signed [64:0] p2_pm1_reg;
    logic signed [65:0] p2_pm2_reg;
    logic [63:0]       p2_bvlo_reg, p2_bvhi_reg;
    logic [64:0]       p2_cglo_reg, p2_cghi_reg;

    // Stage 3: new moments, written back on leaving
    logic              p3_v_reg, p3_in_reg;
    logic [IDX_W-1:0]  p3_idx_reg;
    logic [DATA_W-1:0] p3_w_reg;
    logic [DATA_W-1:0] p3_m_reg;
    logic [V_W-1:0]    p3_vm_reg;

    // Stage 4: numerator
    logic              p4_v_reg;
    tag_t              p4_tag_reg;
    logic [V_W-1:0]    p4_vm_reg;
    logic [NUM_W-1:0]  p4_num_reg;

    logic                     hazard, accept, in_inside;
    logic [DATA_W-1:0]        gmag;
    logic [DATA_W-1:0]        m_rdata;
    logic [V_W-1:0]           v_rdata;
    logic signed [DATA_W-1:0] m_old;
    logic [V_W-1:0]           v_old;
    logic signed [32:0]       b1_s;
    logic [32:0]              cb1, cb2;
    logic signed [33:0]       cb1_s;
    logic signed [66:0]       msum;
    logic [96:0]              vsum;
    logic [DATA_W-1:0]        mmag;
    logic [63:0]              num_full;
    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [DATA_W-1:0]        m_wdata;
    logic [V_W-1:0]           v_wdata;

    // A word may not read an element still being updated further down
    assign hazard = (p1_v_reg && p1_idx_reg == s_elem_index) ||
                    (p2_v_reg && p2_idx_reg == s_elem_index) ||
                    (p3_v_reg && p3_idx_reg == s_elem_index);
    assign s_ready   = adv && !clearing_reg && !hazard;
    assign accept    = s_valid && s_ready;
    assign in_inside = {1'b0, s_elem_index} < (IDX_W+1)'(NUM_ELEMS);

    // Store write port: clearing pass or write-back from stage 3
    assign ram_we    = clearing_reg || (adv && p3_v_reg && p3_in_reg);
    assign ram_waddr = clearing_reg ? clr_cnt_reg : p3_idx_reg[ADDR_W-1:0];
    assign m_wdata   = clearing_reg ? '0 : p3_m_reg;
    assign v_wdata   = clearing_reg ? '0 : p3_vm_reg;

    apu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_ELEMS)) u_m_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (m_wdata),
        .re    (adv),
        .raddr (s_elem_index[ADDR_W-1:0]),
        .rdata (m_rdata)
    );

    apu_ram #(.WIDTH(V_W), .DEPTH(NUM_ELEMS)) u_v_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (v_wdata),
        .re    (adv),
        .raddr (s_elem_index[ADDR_W-1:0]),
        .rdata (v_rdata)
    );

    // Datapath arithmetic per stage
    always_comb begin
        gmag     = s_gradient[DATA_W-1] ? (~s_gradient + 1'b1) : s_gradient;
        m_old    = p1_in_reg ? $signed(m_rdata) : '0;
        v_old    = p1_in_reg ? v_rdata : '0;
        b1_s     = {1'b0, beta_first};
        cb1      = 33'h1_0000_0000 - {1'b0, beta_first};
        cb2      = 33'h1_0000_0000 - {1'b0, beta_second};
        cb1_s    = {1'b0, cb1};
        msum     = p2_pm1_reg + p2_pm2_reg;
        vsum     = {p2_bvhi_reg, 32'b0} + p2_bvlo_reg + {p2_cghi_reg, 32'b0} + p2_cglo_reg;
        mmag     = p3_m_reg[DATA_W-1] ? (~p3_m_reg + 1'b1) : p3_m_reg;
        num_full = mmag * step_size;
    end

    // Clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(NUM_ELEMS - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
            p4_v_reg <= 1'b0;
        end else if (adv) begin
            p1_v_reg <= accept;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
            p4_v_reg <= p3_v_reg;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            p1_in_reg  <= in_inside;
            p1_idx_reg <= s_elem_index;
            p1_w_reg   <= s_weight_in;
            p1_g_reg   <= $signed(s_gradient);
            p1_gg_reg  <= gmag * gmag;

            p2_in_reg   <= p1_in_reg;
            p2_idx_reg  <= p1_idx_reg;
            p2_w_reg    <= p1_w_reg;
            p2_pm1_reg  <= b1_s * m_old;
            p2_pm2_reg  <= cb1_s * p1_g_reg;
            p2_bvlo_reg <= beta_second * v_old[31:0];
            p2_bvhi_reg <= beta_second * v_old[63:32];
            p2_cglo_reg <= cb2 * p1_gg_reg[31:0];
            p2_cghi_reg <= cb2 * p1_gg_reg[63:32];

            p3_in_reg  <= p2_in_reg;
            p3_idx_reg <= p2_idx_reg;
            p3_w_reg   <= p2_w_reg;
            p3_m_reg   <= msum[63:32];
            p3_vm_reg  <= vsum[95:32];

            p4_tag_reg.idx   <= p3_idx_reg;
            p4_tag_reg.w     <= p3_w_reg;
            p4_tag_reg.mneg  <= p3_m_reg[DATA_W-1];
            p4_tag_reg.mzero <= (p3_m_reg == '0);
            p4_vm_reg        <= p3_vm_reg;
            p4_num_reg       <= num_full[NUM_W-1:0];
        end
    end

    assign out_flow.valid = p4_v_reg;
    assign out_flow.tag   = p4_tag_reg;
    assign out_v          = p4_vm_reg;
    assign out_num        = p4_num_reg;

    // Checks
    a_clear_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !(p1_v_reg || p2_v_reg || p3_v_reg))
        else $error("word in moment stages during clearing pass");

    a_clear_len: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> $past(clr_cnt_reg) == ADDR_W'(NUM_ELEMS - 1))
        else $error("clearing pass ended early");

endmodule

`default_nettype wire

// ----- design/apu_isqrt.sv -----
// ----------------------------------------------------------------------------
// apu_isqrt
// Pipelined integer square root of the second moment, one root bit per
// stage, followed by the epsilon add on the way out.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_isqrt
    import apu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic [DATA_W-1:0] epsilon,
    input  flow_t                  in_flow,
    input  wire logic [V_W-1:0]    in_v,
    input  wire logic [NUM_W-1:0]  in_num,
    output flow_t                  out_flow,
    output logic      [DEN_W-1:0]  out_den,
    output logic      [NUM_W-1:0]  out_num
);

    logic              v_reg    [SQ_STEPS+1];
    tag_t              tag_reg  [SQ_STEPS+1];
    logic [V_W-1:0]    x_reg    [SQ_STEPS+1];
    logic [REM_W-1:0]  rem_reg  [SQ_STEPS+1];
    logic [ROOT_W-1:0] root_reg [SQ_STEPS+1];
    logic [NUM_W-1:0]  num_reg  [SQ_STEPS+1];

    logic [REM_W+1:0]  sh_c     [SQ_STEPS];
    logic [REM_W+1:0]  tr_c     [SQ_STEPS];
    logic              ge_c     [SQ_STEPS];
    logic [REM_W-1:0]  rem_next [SQ_STEPS];
    logic [ROOT_W-1:0] root_next[SQ_STEPS];

    // One restoring square root step per stage
    always_comb begin
        for (int k = 0; k < SQ_STEPS; k++) begin
            sh_c[k] = {rem_reg[k], x_reg[k][V_W-1 -: 2]};
            tr_c[k] = {{(REM_W-ROOT_W){1'b0}}, root_reg[k], 2'b01};
            ge_c[k] = sh_c[k] >= tr_c[k];
            rem_next[k]  = ge_c[k] ? REM_W'(sh_c[k] - tr_c[k]) : REM_W'(sh_c[k]);
            root_next[k] = {root_reg[k][ROOT_W-2:0], ge_c[k]};
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= SQ_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= in_flow.valid;
            for (int k = 0; k < SQ_STEPS; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0]  <= in_flow.tag;
            x_reg[0]    <= in_v;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            num_reg[0]  <= in_num;
            for (int k = 0; k < SQ_STEPS; k++) begin
                tag_reg[k+1]  <= tag_reg[k];
                x_reg[k+1]    <= {x_reg[k][V_W-3:0], 2'b00};
                rem_reg[k+1]  <= rem_next[k];
                root_reg[k+1] <= root_next[k];
                num_reg[k+1]  <= num_reg[k];
            end
        end
    end

    assign out_flow.valid = v_reg[SQ_STEPS];
    assign out_flow.tag   = tag_reg[SQ_STEPS];
    assign out_den        = {1'b0, root_reg[SQ_STEPS]} + {1'b0, epsilon};
    assign out_num        = num_reg[SQ_STEPS];

endmodule

`default_nettype wire

// ----- design/apu_div.sv -----
// ----------------------------------------------------------------------------
// apu_div
// Pipelined restoring divider for the step size, one quotient bit per
// stage, then clipping, sign and saturating weight update.
// ----------------------------------------------------------------------------
`default_nettype none

module apu_div
    import apu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  flow_t                  in_flow,
    input  wire logic [DEN_W-1:0]  in_den,
    input  wire logic [NUM_W-1:0]  in_num,
    output logic                   out_valid,
    output logic      [IDX_W-1:0]  out_idx,
    output logic      [DATA_W-1:0] out_weight
);

    logic              v_reg   [DIV_STEPS+1];
    tag_t              tag_reg [DIV_STEPS+1];
    logic [DEN_W-1:0]  den_reg [DIV_STEPS+1];
    logic [DEN_W-1:0]  rem_reg [DIV_STEPS+1];
    logic [Q_W-1:0]    lo_reg  [DIV_STEPS+1];
    logic [Q_W-1:0]    q_reg   [DIV_STEPS+1];
    logic              ovf_reg [DIV_STEPS+1];
    logic              dz_reg  [DIV_STEPS+1];

    logic [DEN_W:0]    sh_c     [DIV_STEPS];
    logic              ge_c     [DIV_STEPS];
    logic [DEN_W-1:0]  rem_next [DIV_STEPS];

    logic              fin_v_reg;
    logic [IDX_W-1:0]  fin_idx_reg;
    logic [DATA_W-1:0] fin_w_reg;

    logic [N_W-1:0]    n_c;
    logic [HI_W-1:0]   hi_c;
    logic [Q_W-1:0]    step_c;
    logic signed [RES_W-1:0] w_ext, res_c;
    logic [DATA_W-1:0] sat_c;

    // Numerator over 16, top part checked against the divisor for overflow
    assign n_c  = in_num[NUM_W-1:4];
    assign hi_c = n_c[N_W-1:Q_W];

    // One quotient bit per stage
    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            sh_c[k] = {rem_reg[k], lo_reg[k][Q_W-1]};
            ge_c[k] = sh_c[k] >= {1'b0, den_reg[k]};
            rem_next[k] = ge_c[k] ? DEN_W'(sh_c[k] - {1'b0, den_reg[k]})
                                  : DEN_W'(sh_c[k]);
        end
    end

    // Step clipping, sign and saturation
    always_comb begin
        if (tag_reg[DIV_STEPS].mzero) begin
            step_c = '0;
        end else if (ovf_reg[DIV_STEPS] || dz_reg[DIV_STEPS] ||
                     q_reg[DIV_STEPS] > STEP_CLIP) begin
            step_c = STEP_CLIP;
        end else begin
            step_c = q_reg[DIV_STEPS];
        end
        w_ext = RES_W'($signed(tag_reg[DIV_STEPS].w));
        if (tag_reg[DIV_STEPS].mneg) begin
            res_c = w_ext + $signed({2'b00, step_c});
        end else begin
            res_c = w_ext - $signed({2'b00, step_c});
        end
        if (res_c[RES_W-1:DATA_W-1] == '0 || res_c[RES_W-1:DATA_W-1] == '1) begin
            sat_c = res_c[DATA_W-1:0];
        end else if (res_c[RES_W-1]) begin
            sat_c = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            sat_c = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                v_reg[k] <= 1'b0;
            end
            fin_v_reg <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_flow.valid;
            for (int k = 0; k < DIV_STEPS; k++) begin
                v_reg[k+1] <= v_reg[k];
            end
            fin_v_reg <= v_reg[DIV_STEPS];
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            tag_reg[0] <= in_flow.tag;
            den_reg[0] <= in_den;
            rem_reg[0] <= DEN_W'(hi_c);
            lo_reg[0]  <= n_c[Q_W-1:0];
            q_reg[0]   <= '0;
            ovf_reg[0] <= {{(DEN_W-HI_W){1'b0}}, hi_c} >= in_den;
            dz_reg[0]  <= (in_den == '0);
            for (int k = 0; k < DIV_STEPS; k++) begin
                tag_reg[k+1] <= tag_reg[k];
                den_reg[k+1] <= den_reg[k];
                rem_reg[k+1] <= rem_next[k];
                lo_reg[k+1]  <= {lo_reg[k][Q_W-2:0], 1'b0};
                q_reg[k+1]   <= {q_reg[k][Q_W-2:0], ge_c[k]};
                ovf_reg[k+1] <= ovf_reg[k];
                dz_reg[k+1]  <= dz_reg[k];
            end
            fin_idx_reg <= tag_reg[DIV_STEPS].idx;
            fin_w_reg   <= sat_c;
        end
    end

    assign out_valid  = fin_v_reg;
    assign out_idx    = fin_idx_reg;
    assign out_weight = fin_w_reg;

endmodule

`default_nettype wire

// ----- design/adam_parameter_update.sv -----
// ----------------------------------------------------------------------------
// adam_parameter_update
// Fixed-point Adam step per element: moment stores, square root and
// divider pipelines, saturating weight update, output register with skid.
// ----------------------------------------------------------------------------
//  Channel   Ports                                     Direction
//  input     s_valid/s_ready, s_elem_index,            in
//            s_weight_in, s_gradient
//  result    m_valid/m_ready, m_result_index,          out
//            m_weight_out
//  config    cfg_we, cfg_index, cfg_wdata              in, write only
//
//  One word per cycle unless a hazard, the clearing pass or a full skid
//  register holds the input. A word whose index matches one of the three
//  words still updating the moment stores (read, multiply, sum, write back)
//  waits until they have written back. After reset a clearing pass zeroes
//  all 4096 entries of both stores and takes no input. The pipeline moves as
//  a whole; the skid register holds one more result while the output waits.
// ----------------------------------------------------------------------------
`default_nettype none

module adam_parameter_update
    import apu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [DATA_W-1:0] cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [IDX_W-1:0]  s_elem_index,
    input  wire logic [DATA_W-1:0] s_weight_in,
    input  wire logic [DATA_W-1:0] s_gradient,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [IDX_W-1:0]  m_result_index,
    output logic      [DATA_W-1:0] m_weight_out
);

    logic [DATA_W-1:0] lr_reg, b1_reg, b2_reg, eps_reg;

    logic              adv;
    flow_t             mom_flow, sq_flow;
    logic [V_W-1:0]    mom_v;
    logic [NUM_W-1:0]  mom_num, sq_num;
    logic [DEN_W-1:0]  sq_den;
    logic              fin_v;
    logic [IDX_W-1:0]  fin_idx;
    logic [DATA_W-1:0] fin_w;

    logic              out_v_reg, skid_v_reg;
    logic [IDX_W-1:0]  out_idx_reg, skid_idx_reg;
    logic [DATA_W-1:0] out_w_reg, skid_w_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg  <= LR_RESET;
            b1_reg  <= B1_RESET;
            b2_reg  <= B2_RESET;
            eps_reg <= EPS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_STEP_SIZE:     lr_reg  <= cfg_wdata;
                CFG_BETA_FIRST:    b1_reg  <= cfg_wdata;
                CFG_BETA_SECOND:   b2_reg  <= cfg_wdata;
                CFG_EPSILON:       eps_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Whole pipeline moves unless the skid register is occupied
    assign adv = !skid_v_reg;

    apu_moment u_moment (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .step_size     (lr_reg),
        .beta_first    (b1_reg),
        .beta_second   (b2_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_elem_index  (s_elem_index),
        .s_weight_in   (s_weight_in),
        .s_gradient    (s_gradient),
        .out_flow      (mom_flow),
        .out_v         (mom_v),
        .out_num       (mom_num)
    );

    apu_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .epsilon  (eps_reg),
        .in_flow  (mom_flow),
        .in_v     (mom_v),
        .in_num   (mom_num),
        .out_flow (sq_flow),
        .out_den  (sq_den),
        .out_num  (sq_num)
    );

    apu_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_flow    (sq_flow),
        .in_den     (sq_den),
        .in_num     (sq_num),
        .out_valid  (fin_v),
        .out_idx    (fin_idx),
        .out_weight (fin_w)
    );

    // Output register and skid: control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (out_v_reg && !m_ready) begin
            if (adv && fin_v) begin
                skid_v_reg <= 1'b1;
            end
        end else if (skid_v_reg) begin
            out_v_reg  <= 1'b1;
            skid_v_reg <= 1'b0;
        end else begin
            out_v_reg <= adv && fin_v;
        end
    end

    // Output register and skid: data
    always_ff @(posedge aclk) begin
        if (out_v_reg && !m_ready) begin
            if (adv && fin_v) begin
                skid_idx_reg <= fin_idx;
                skid_w_reg   <= fin_w;
            end
        end else if (skid_v_reg) begin
            out_idx_reg <= skid_idx_reg;
            out_w_reg   <= skid_w_reg;
        end else begin
            out_idx_reg <= fin_idx;
            out_w_reg   <= fin_w;
        end
    end

    assign m_valid        = out_v_reg;
    assign m_result_index = out_idx_reg;
    assign m_weight_out   = out_w_reg;

    // Checks
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid word held with empty output register");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_ready))
        else $error("skid filled while output was free");

endmodule

`default_nettype wire
